// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== sv/rwlt_pkg.sv =====
package rwlt_pkg;

	// table depth, a power of two so the index reduces by masking
	localparam int NUM_RESOURCES = 1024;
	localparam int MAX_READERS   = 255;
	localparam int ADDR_W        = $clog2(NUM_RESOURCES);
	localparam int COUNT_W       = 8;
	localparam logic [COUNT_W-1:0] READER_CAP =
		(MAX_READERS > 255) ? 8'd255 : COUNT_W'(MAX_READERS);

	typedef enum logic [2:0] {
		OP_SH_ACQ = 3'd0,
		OP_EX_ACQ = 3'd1,
		OP_SH_REL = 3'd2,
		OP_EX_REL = 3'd3,
		OP_POLL   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_WRITER = 3'd1,
		ST_WAIT   = 3'd2,
		ST_SAT    = 3'd3,
		ST_NONE   = 3'd4
	} status_t;

	typedef struct packed {
		logic               writer;
		logic [COUNT_W-1:0] readers;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_LOOKUP
	} fsm_t;

endpackage

// ===== sv/rwlt_ram.sv =====
module rwlt_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== sv/rwlt_update.sv =====
module rwlt_update (
	input  logic [2:0]       op,
	input  rwlt_pkg::entry_t cur,
	output rwlt_pkg::entry_t nxt,
	output rwlt_pkg::status_t status
);
	import rwlt_pkg::*;

	always_comb begin
		nxt    = cur;
		status = ST_OK;
		unique case (op)
			OP_SH_ACQ: begin
				if (cur.writer) begin
					status = ST_WRITER;
				end else if (cur.readers >= READER_CAP) begin
					status = ST_SAT;
				end else begin
					nxt.readers = cur.readers + 1'b1;
				end
			end
			OP_EX_ACQ: begin
				if (cur.writer) begin
					status = ST_WRITER;
				end else begin
					nxt.writer = 1'b1;
					status     = (cur.readers == '0) ? ST_OK : ST_WAIT;
				end
			end
			OP_SH_REL: begin
				if (cur.readers != '0) begin
					nxt.readers = cur.readers - 1'b1;
				end else begin
					status = ST_NONE;
				end
			end
			OP_EX_REL: begin
				status      = cur.writer ? ST_OK : ST_NONE;
				nxt.writer  = 1'b0;
				nxt.readers = '0;
			end
			OP_POLL: begin
				status = (cur.readers == '0) ? ST_OK : ST_WAIT;
			end
			default: begin
				// unknown codes leave the entry as it is
				nxt    = cur;
				status = ST_OK;
			end
		endcase
	end

endmodule

// ===== sv/reader_writer_lock_table.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    operation, resource_index
// out      output     out_valid / out_ready  status, readers_now, writer_now
//
// each item: table read, then update, write back and result load
// the single-port entry memory takes one read and one write per item; a new item enters after write back
// after reset a clearing pass writes all 1024 entries, no item taken
// a waiting result holds the update step and the input; one more item may enter first
module reader_writer_lock_table (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [9:0] resource_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [7:0] readers_now,
	output logic       writer_now
);
	import rwlt_pkg::*;

	`include "assert_macros.svh"

	fsm_t              state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [2:0]        op_q;
	logic [ADDR_W-1:0] idx_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        readers_q;
	logic              writer_q;

	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	entry_t             cur_entry, new_entry;
	status_t            new_status;
	logic               load_out;

	rwlt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_RESOURCES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign cur_entry = entry_t'(ram_rdata);

	rwlt_update u_update (
		.op    (op_q),
		.cur   (cur_entry),
		.nxt   (new_entry),
		.status(new_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= operation;
			idx_q <= resource_index[ADDR_W-1:0];
		end
		if (load_out) begin
			status_q  <= new_status;
			readers_q <= new_entry.readers;
			writer_q  <= new_entry.writer;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = new_entry;
		load_out  = 1'b0;
		unique case (state_q)
			FSM_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(NUM_RESOURCES - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				in_ready = 1'b1;
				ram_addr = resource_index[ADDR_W-1:0];
				if (in_valid) begin
					ram_re  = 1'b1;
					state_d = FSM_LOOKUP;
				end
			end
			FSM_LOOKUP: begin
				if (!out_valid_q || out_ready) begin
					ram_we   = 1'b1;
					load_out = 1'b1;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign readers_now = readers_q;
	assign writer_now  = writer_q;

	`ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, state_q == FSM_CLEAR, !in_ready)
	`ASSERT_IMP(a_port_exclusive, clk, arst_n, ram_we, !ram_re)
	`ASSERT_NEXT(a_accept_to_lookup, clk, arst_n, in_valid && in_ready, state_q == FSM_LOOKUP)
	`ASSERT_NEXT(a_load_sets_valid, clk, arst_n, load_out, out_valid_q)

endmodule
